@@ hw/rtl/nfc_pkg.sv @@
package nfc_pkg;

	// vectoring datapath: 33-bit differences scaled by 2^24, plus CORDIC growth
	localparam int VEC_W = 60;
	localparam int VEC_SCALE = 24;
	// rotation datapath: Q2.30 values with headroom
	localparam int ROT_W = 34;
	localparam int MAX_STAGES = 32;
	localparam logic [31:0] HALF_TURN = 32'h8000_0000;
	localparam logic [31:0] GAIN_INV = 32'd652032874;
	localparam int Q15_HALF = 16384;
	localparam int Q15_SHIFT = 15;
	localparam logic signed [15:0] Q15_MAX = 16'sh7FFF;
	localparam logic signed [15:0] Q15_MIN = 16'sh8000;

	typedef struct packed {
		logic iso;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic last;
	} tag_t;

	typedef struct packed {
		logic valid;
		tag_t tag;
	} ctl_t;

	typedef struct packed {
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic [31:0] z;
	} vec_t;

	typedef struct packed {
		logic signed [ROT_W-1:0] x;
		logic signed [ROT_W-1:0] y;
		logic signed [ROT_W-1:0] z;
	} rot_t;

	// atan(2^-i) as a 32-bit binary angle
	function automatic logic [31:0] atan_entry(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0: r = 32'h20000000;
			5'd1: r = 32'h12E4051E;
			5'd2: r = 32'h09FB385B;
			5'd3: r = 32'h051111D4;
			5'd4: r = 32'h028B0D43;
			5'd5: r = 32'h0145D7E1;
			5'd6: r = 32'h00A2F61E;
			5'd7: r = 32'h00517C55;
			5'd8: r = 32'h0028BE53;
			5'd9: r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000029;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000003;
			5'd29: r = 32'h00000001;
			5'd30: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

@@ hw/rtl/normal_from_covariance_2d.sv @@
// Throughput: one point per cycle; busy is tied low, so every start is taken.
// The two CORDIC chains (one cell per iteration) plus four fixed stages set the latency.
// Each result shows for one cycle with done; the receiver cannot stall it.
// Reset (arst_n low) clears every valid bit in the chain; in-flight points are dropped.
module normal_from_covariance_2d #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [31:0]         cov_xx,
	input  logic signed [31:0]  cov_xy,
	input  logic [31:0]         cov_yy,
	input  logic signed [31:0]  point_x,
	input  logic signed [31:0]  point_y,
	input  logic                last_in,
	output logic                done,
	output logic signed [15:0]  normal_x,
	output logic signed [15:0]  normal_y,
	output logic                last_out
);

	localparam int N = (CORDIC_STAGES > nfc_pkg::MAX_STAGES) ? nfc_pkg::MAX_STAGES
		: CORDIC_STAGES;
	localparam int VW = nfc_pkg::VEC_W;
	localparam int RW = nfc_pkg::ROT_W;

	logic signed [32:0] diff_pos, diff_neg, b2;
	logic a_neg;
	logic signed [VW-1:0] mag_ext, b_ext;
	nfc_pkg::vec_t vec_c;

	logic valid_s0;
	nfc_pkg::tag_t tag_s0;
	nfc_pkg::vec_t vec_s0;

	nfc_pkg::ctl_t vctl [0:N];
	nfc_pkg::vec_t vvec [0:N];
	nfc_pkg::ctl_t rctl [0:N];
	nfc_pkg::rot_t rrot [0:N];

	assign busy = 1'b0;

	assign diff_pos = signed'({1'b0, cov_xx}) - signed'({1'b0, cov_yy});
	assign diff_neg = signed'({1'b0, cov_yy}) - signed'({1'b0, cov_xx});
	assign a_neg = (cov_yy > cov_xx);
	assign b2 = {cov_xy, 1'b0};

	// fold a negative x into the right half plane, starting at half a turn
	always_comb begin
		mag_ext = VW'(a_neg ? diff_neg : diff_pos);
		b_ext = VW'(b2);
		vec_c.x = mag_ext <<< nfc_pkg::VEC_SCALE;
		vec_c.y = a_neg ? -(b_ext <<< nfc_pkg::VEC_SCALE) : (b_ext <<< nfc_pkg::VEC_SCALE);
		vec_c.z = a_neg ? nfc_pkg::HALF_TURN : 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else begin
			valid_s0 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		tag_s0.iso <= (cov_xx == cov_yy) && (cov_xy == 32'sd0);
		tag_s0.px <= point_x;
		tag_s0.py <= point_y;
		tag_s0.last <= last_in;
		vec_s0 <= vec_c;
	end

	assign vctl[0] = '{valid: valid_s0, tag: tag_s0};
	assign vvec[0] = vec_s0;

	for (genvar i = 0; i < N; i++) begin : g_vec
		nfc_vec_cell #(.STAGE(i)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.in_ctl  (vctl[i]),
			.in_vec  (vvec[i]),
			.out_ctl (vctl[i+1]),
			.out_vec (vvec[i+1])
		);
	end

	// half of the signed angle seeds the rotation
	assign rctl[0] = vctl[N];
	assign rrot[0].x = signed'(RW'(nfc_pkg::GAIN_INV));
	assign rrot[0].y = '0;
	assign rrot[0].z = RW'(signed'(vvec[N].z) >>> 1);

	for (genvar i = 0; i < N; i++) begin : g_rot
		nfc_rot_cell #(.STAGE(i)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.in_ctl  (rctl[i]),
			.in_rot  (rrot[i]),
			.out_ctl (rctl[i+1]),
			.out_rot (rrot[i+1])
		);
	end

	nfc_orient u_orient (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ctl   (rctl[N]),
		.in_rot   (rrot[N]),
		.done     (done),
		.normal_x (normal_x),
		.normal_y (normal_y),
		.last_out (last_out)
	);

endmodule

@@ hw/rtl/nfc_vec_cell.sv @@
module nfc_vec_cell #(
	parameter int STAGE = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  nfc_pkg::ctl_t  in_ctl,
	input  nfc_pkg::vec_t  in_vec,
	output nfc_pkg::ctl_t  out_ctl,
	output nfc_pkg::vec_t  out_vec
);

	logic signed [nfc_pkg::VEC_W-1:0] x, y, dx, dy;
	logic [31:0] at;
	nfc_pkg::vec_t nxt;
	logic valid_q;
	nfc_pkg::tag_t tag_q;
	nfc_pkg::vec_t vec_q;

	assign x = in_vec.x;
	assign y = in_vec.y;
	assign dx = y >>> STAGE;
	assign dy = x >>> STAGE;
	assign at = nfc_pkg::atan_entry(5'(STAGE));

	// drive y toward zero, accumulating the angle
	always_comb begin
		if (!y[nfc_pkg::VEC_W-1]) begin
			nxt.x = x + dx;
			nxt.y = y - dy;
			nxt.z = in_vec.z + at;
		end else begin
			nxt.x = x - dx;
			nxt.y = y + dy;
			nxt.z = in_vec.z - at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		tag_q <= in_ctl.tag;
		vec_q <= nxt;
	end

	assign out_ctl = '{valid: valid_q, tag: tag_q};
	assign out_vec = vec_q;

endmodule

@@ hw/rtl/nfc_rot_cell.sv @@
module nfc_rot_cell #(
	parameter int STAGE = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  nfc_pkg::ctl_t  in_ctl,
	input  nfc_pkg::rot_t  in_rot,
	output nfc_pkg::ctl_t  out_ctl,
	output nfc_pkg::rot_t  out_rot
);

	logic signed [nfc_pkg::ROT_W-1:0] x, y, z, dx, dy, at;
	nfc_pkg::rot_t nxt;
	logic valid_q;
	nfc_pkg::tag_t tag_q;
	nfc_pkg::rot_t rot_q;

	assign x = in_rot.x;
	assign y = in_rot.y;
	assign z = in_rot.z;
	assign dx = y >>> STAGE;
	assign dy = x >>> STAGE;
	assign at = signed'(nfc_pkg::ROT_W'(nfc_pkg::atan_entry(5'(STAGE))));

	// rotate toward residual angle zero
	always_comb begin
		if (!z[nfc_pkg::ROT_W-1]) begin
			nxt.x = x - dx;
			nxt.y = y + dy;
			nxt.z = z - at;
		end else begin
			nxt.x = x + dx;
			nxt.y = y - dy;
			nxt.z = z + at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		tag_q <= in_ctl.tag;
		rot_q <= nxt;
	end

	assign out_ctl = '{valid: valid_q, tag: tag_q};
	assign out_rot = rot_q;

endmodule

@@ hw/rtl/nfc_orient.sv @@
module nfc_orient (
	input  logic                clk,
	input  logic                arst_n,
	input  nfc_pkg::ctl_t       in_ctl,
	input  nfc_pkg::rot_t       in_rot,
	output logic                done,
	output logic signed [15:0]  normal_x,
	output logic signed [15:0]  normal_y,
	output logic                last_out
);

	localparam int VW = nfc_pkg::ROT_W + 1;

	function automatic logic signed [15:0] to_q15(input logic signed [VW-1:0] v);
		logic signed [VW-1:0] r;
		logic signed [15:0] q;
		r = (v + signed'(VW'(nfc_pkg::Q15_HALF))) >>> nfc_pkg::Q15_SHIFT;
		if (!r[VW-1] && (|r[VW-2:15])) begin
			q = nfc_pkg::Q15_MAX;
		end else if (r[VW-1] && !(&r[VW-2:15])) begin
			q = nfc_pkg::Q15_MIN;
		end else begin
			q = r[15:0];
		end
		return q;
	endfunction

	function automatic logic signed [15:0] neg_sat(input logic signed [15:0] v);
		logic signed [15:0] r;
		if (v == nfc_pkg::Q15_MIN) begin
			r = nfc_pkg::Q15_MAX;
		end else begin
			r = -v;
		end
		return r;
	endfunction

	logic signed [VW-1:0] sin_neg, cos_ext;
	logic signed [15:0] nx_c, ny_c;

	logic valid_s1, valid_s2, done_q;
	nfc_pkg::tag_t tag_s1, tag_s2;
	logic signed [15:0] nx_s1, ny_s1, nx_s2, ny_s2;
	logic signed [47:0] px_p_s2, py_p_s2;
	logic signed [48:0] dot;
	logic signed [15:0] nx_q, ny_q;
	logic last_q;

	assign sin_neg = -{in_rot.y[nfc_pkg::ROT_W-1], in_rot.y};
	assign cos_ext = {in_rot.x[nfc_pkg::ROT_W-1], in_rot.x};

	// isotropic covariance: take the unrotated normal
	always_comb begin
		if (in_ctl.tag.iso) begin
			nx_c = 16'sd0;
			ny_c = nfc_pkg::Q15_MAX;
		end else begin
			nx_c = to_q15(sin_neg);
			ny_c = to_q15(cos_ext);
		end
	end

	assign dot = {px_p_s2[47], px_p_s2} + {py_p_s2[47], py_p_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			valid_s1 <= in_ctl.valid;
			valid_s2 <= valid_s1;
			done_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1 <= in_ctl.tag;
		nx_s1 <= nx_c;
		ny_s1 <= ny_c;

		tag_s2 <= tag_s1;
		nx_s2 <= nx_s1;
		ny_s2 <= ny_s1;
		px_p_s2 <= tag_s1.px * nx_s1;
		py_p_s2 <= tag_s1.py * ny_s1;

		// flip to face the origin
		if (!dot[48] && (|dot)) begin
			nx_q <= neg_sat(nx_s2);
			ny_q <= neg_sat(ny_s2);
		end else begin
			nx_q <= nx_s2;
			ny_q <= ny_s2;
		end
		last_q <= tag_s2.last;
	end

	assign done = done_q;
	assign normal_x = nx_q;
	assign normal_y = ny_q;
	assign last_out = last_q;

endmodule

@@ test/normal_from_covariance_2d_tb.sv @@
module normal_from_covariance_2d_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STAGES = 16;
	localparam int RUN_STAGES = (STAGES > 32) ? 32 : STAGES;
	localparam int POINT_COUNT = 750;
	localparam int CYCLE_LIMIT = 100000;
	localparam longint GAIN_Q30 = 652032874;

	// atan(2^-i) in binary-angle units, 2^32 per turn
	localparam logic [31:0] ARCTAN [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
		32'h00000001, 32'h00000000
	};

	typedef struct {
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic last;
	} normal_t;

	class normal_book;
		normal_t expected_q[$];
		int failures;

		function new();
			failures = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function logic signed [15:0] round_q15(longint v);
			longint r;
			r = (v + 16384) >>> 15;
			if (r > 32767)
				r = 32767;
			else if (r < -32768)
				r = -32768;
			return r[15:0];
		endfunction

		function normal_t predict(logic [31:0] xx, logic signed [31:0] xy, logic [31:0] yy,
				logic signed [31:0] px, logic signed [31:0] py, logic last);
			longint a, b, vx, vy, rx, ry, rz, dx, dy, nx, ny, dot, step;
			logic [31:0] ang;
			normal_t n;
			a = longint'({32'd0, xx}) - longint'({32'd0, yy});
			b = 2 * longint'(xy);
			if (a == 0 && b == 0) begin
				nx = 0;
				ny = 32767;
			end else begin
				// vectoring pass: angle of (a, b)
				vx = a * 16777216;
				vy = b * 16777216;
				ang = '0;
				if (vx < 0) begin
					vx = -vx;
					vy = -vy;
					ang = 32'h8000_0000;
				end
				for (int i = 0; i < RUN_STAGES; i++) begin
					dx = vy >>> i;
					dy = vx >>> i;
					if (vy >= 0) begin
						vx += dx;
						vy -= dy;
						ang += ARCTAN[i];
					end else begin
						vx -= dx;
						vy += dy;
						ang -= ARCTAN[i];
					end
				end
				// rotation pass on the half angle
				rz = longint'(signed'(ang)) >>> 1;
				rx = GAIN_Q30;
				ry = 0;
				for (int i = 0; i < RUN_STAGES; i++) begin
					dx = ry >>> i;
					dy = rx >>> i;
					step = longint'({32'd0, ARCTAN[i]});
					if (rz >= 0) begin
						rx -= dx;
						ry += dy;
						rz -= step;
					end else begin
						rx += dx;
						ry -= dy;
						rz += step;
					end
				end
				nx = longint'(round_q15(-ry));
				ny = longint'(round_q15(rx));
			end
			// turn the normal toward the origin
			dot = longint'(px) * nx + longint'(py) * ny;
			if (dot > 0) begin
				nx = -nx;
				ny = -ny;
				if (nx > 32767)
					nx = 32767;
				if (ny > 32767)
					ny = 32767;
			end
			n.nx = nx[15:0];
			n.ny = ny[15:0];
			n.last = last;
			return n;
		endfunction

		function void note_point(logic [31:0] xx, logic signed [31:0] xy, logic [31:0] yy,
				logic signed [31:0] px, logic signed [31:0] py, logic last);
			expected_q.push_back(predict(xx, xy, yy, px, py, last));
		endfunction

		function void check_normal(logic signed [15:0] nx, logic signed [15:0] ny, logic last);
			normal_t e;
			if (expected_q.size() == 0) begin
				$error("unexpected result: normal_x %0d normal_y %0d last_out %0d", nx, ny, last);
				failures++;
				return;
			end
			e = expected_q.pop_front();
			if (nx !== e.nx) begin
				$error("normal_x: expected %0d, got %0d", e.nx, nx);
				failures++;
			end
			if (ny !== e.ny) begin
				$error("normal_y: expected %0d, got %0d", e.ny, ny);
				failures++;
			end
			if (last !== e.last) begin
				$error("last_out: expected %0d, got %0d", e.last, last);
				failures++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [31:0] cov_xx;
	logic signed [31:0] cov_xy;
	logic [31:0] cov_yy;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic last_in;
	logic done;
	logic signed [15:0] normal_x;
	logic signed [15:0] normal_y;
	logic last_out;
	int cycle_count;

	normal_book book = new();

	normal_from_covariance_2d #(
		.CORDIC_STAGES(STAGES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cov_xx(cov_xx),
		.cov_xy(cov_xy),
		.cov_yy(cov_yy),
		.point_x(point_x),
		.point_y(point_y),
		.last_in(last_in),
		.done(done),
		.normal_x(normal_x),
		.normal_y(normal_y),
		.last_out(last_out)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && start && !busy)
			book.note_point(cov_xx, cov_xy, cov_yy, point_x, point_y, last_in);
		if (arst_n && done)
			book.check_normal(normal_x, normal_y, last_out);
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	task automatic drive_point(input logic [31:0] xx, input logic signed [31:0] xy,
			input logic [31:0] yy, input logic signed [31:0] px, input logic signed [31:0] py,
			input logic last);
		@(negedge clk);
		cov_xx <= xx;
		cov_xy <= xy;
		cov_yy <= yy;
		point_x <= px;
		point_y <= py;
		last_in <= last;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// drop start and scramble the payload so ignored inputs are exercised
	task automatic hold_off(input int n);
		@(negedge clk);
		start <= 1'b0;
		cov_xx <= $urandom();
		cov_xy <= $urandom();
		cov_yy <= $urandom();
		point_x <= $urandom();
		point_y <= $urandom();
		last_in <= ($urandom_range(0, 1) == 1);
		repeat (n - 1)
			@(negedge clk);
	endtask

	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (book.pending() > 0)
			@(posedge clk);
	endtask

	task automatic send_random_point();
		logic [31:0] xx, yy;
		logic signed [31:0] xy, px, py;
		logic last;
		case ($urandom_range(0, 5))
			0: begin
				xx = $urandom();
				yy = $urandom();
				xy = $urandom();
			end
			1: begin
				xx = $urandom();
				yy = xx;
				xy = (($urandom_range(0, 1) == 0) ? 32'sd0 : $signed($urandom()) >>> $urandom_range(0, 31));
			end
			2: begin
				xx = $urandom_range(0, 255);
				yy = $urandom_range(0, 255);
				xy = $urandom_range(0, 64) - 32;
			end
			3: begin
				xx = $urandom();
				yy = $urandom();
				xy = 32'sd0;
			end
			4: begin
				xx = 32'hFFFF_FFFF - $urandom_range(0, 15);
				yy = $urandom_range(0, 15);
				xy = $urandom();
				if ($urandom_range(0, 1) == 1) begin
					yy = xx;
					xx = $urandom_range(0, 15);
				end
			end
			default: begin
				xx = $urandom() >> $urandom_range(0, 31);
				yy = $urandom() >> $urandom_range(0, 31);
				xy = $signed($urandom()) >>> $urandom_range(0, 31);
			end
		endcase
		if ($urandom_range(0, 3) == 0) begin
			px = $signed($urandom()) >>> $urandom_range(16, 31);
			py = $signed($urandom()) >>> $urandom_range(16, 31);
		end else begin
			px = $urandom();
			py = $urandom();
		end
		last = ($urandom_range(0, 15) == 0);
		drive_point(xx, xy, yy, px, py, last);
	endtask

	initial begin
		int sent;
		int burst;
		bit drained_mid;
		arst_n = 1'b0;
		start = 1'b0;
		cov_xx = '0;
		cov_xy = '0;
		cov_yy = '0;
		point_x = '0;
		point_y = '0;
		last_in = 1'b0;
		sent = 0;
		drained_mid = 1'b0;
		repeat (11)
			@(negedge clk);
		arst_n <= 1'b1;

		// isotropic covariance, point on, above and below the x axis
		drive_point(32'd0, 32'sd0, 32'd0, 32'sd0, 32'sd0, 1'b0);
		drive_point(32'hFFFF_FFFF, 32'sd0, 32'hFFFF_FFFF, 32'sd0, 32'sd1, 1'b1);
		drive_point(32'h0001_0000, 32'sd0, 32'h0001_0000, 32'sd5, -32'sd1, 1'b0);
		// extremes of the covariance and of the point
		drive_point(32'hFFFF_FFFF, 32'sd0, 32'd0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
		drive_point(32'd0, 32'sd0, 32'hFFFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
		drive_point(32'd0, 32'sh7FFF_FFFF, 32'd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
		drive_point(32'd0, 32'sh8000_0000, 32'd0, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
		drive_point(32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 32'sd1, 32'sd1, 1'b0);
		drive_point(32'hFFFF_FFFF, 32'sh8000_0000, 32'hFFFF_FFFF, -32'sd1, -32'sd1, 1'b0);
		drive_point(32'd0, 32'sh8000_0000, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'sd0, 1'b1);
		drive_point(32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'd0, 32'sd0, 32'sh8000_0000, 1'b0);
		// tiny differences: normal near the axes, orientation flip may saturate
		drive_point(32'd0, 32'sd0, 32'd1, 32'sd1, 32'sd0, 1'b0);
		drive_point(32'd0, 32'sd0, 32'd1, -32'sd1, 32'sd0, 1'b1);
		drive_point(32'd0, 32'sd1, 32'd1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
		drive_point(32'd0, -32'sd1, 32'd1, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
		drive_point(32'd1, 32'sd0, 32'd0, 32'sd3, 32'sd3, 1'b0);
		drive_point(32'd0, 32'sd1, 32'd0, -32'sd3, 32'sd3, 1'b1);
		drive_point(32'd0, -32'sd1, 32'd0, 32'sd3, -32'sd3, 1'b0);
		drive_point(32'd5, 32'sd0, 32'd5, 32'sh8000_0000, -32'sd1, 1'b1);
		drive_point(32'hAAAA_AAAA, 32'sh5555_5555, 32'h5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
			1'b0);
		drive_point(32'h5555_5555, 32'shAAAA_AAAA, 32'hAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
			1'b1);
		drain_results();

		while (sent < POINT_COUNT) begin
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst && sent < POINT_COUNT; k++) begin
				send_random_point();
				sent++;
			end
			if ($urandom_range(0, 3) != 0)
				hold_off($urandom_range(1, 12));
			// let the pipeline empty once in the middle of the run
			if (!drained_mid && sent >= POINT_COUNT / 2) begin
				drain_results();
				drained_mid = 1'b1;
			end
		end
		drain_results();
		repeat (2 * STAGES + 8)
			@(posedge clk);

		if (book.failures == 0 && book.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
